[sv/cbba_pkg.sv]
// shared constants, codes and types of the colored bitmap block allocator
`default_nettype none
package cbba_pkg;
   localparam int MAP_DEPTH   = 8192;
   localparam int BLOCK_BYTES = 1024;
   localparam int ADDR_W      = $clog2(MAP_DEPTH);
   localparam int CNT_W       = ADDR_W + 1;
   localparam int BLK_SHIFT   = $clog2(BLOCK_BYTES);
   localparam int COLOR_W     = 8;
   localparam int REQ_W       = 24;
   localparam int TOTAL_W     = 14;
   localparam int OFFSET_W    = 23;
   localparam int BYTES_W     = 24;
   localparam int NEED_W      = REQ_W - BLK_SHIFT + 1;
   localparam int RESET_TOTAL = (MAP_DEPTH < 8192) ? MAP_DEPTH : 8192;

   typedef enum logic [1:0] {
      STAT_OK         = 2'd0,
      STAT_BAD_SIZE   = 2'd1,
      STAT_NO_SPACE   = 2'd2,
      STAT_BAD_OFFSET = 2'd3
   } status_type;

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } cmd_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ALLOC_LOAD,
      ST_ALLOC_SCAN,
      ST_ALLOC_PAINT,
      ST_FREE_LOOK,
      ST_FREE_BACK,
      ST_FREE_CLR,
      ST_FREE_CHK,
      ST_RESP
   } state_type;
endpackage
`default_nettype wire

[sv/cbba_if.sv]
// channel interfaces: request, response and configuration write
`default_nettype none
interface cbba_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [23:0] request_bytes;
   logic [23:0] free_offset;
   modport source (output valid, cmd, request_bytes, free_offset, input ready);
   modport sink (input valid, cmd, request_bytes, free_offset, output ready);
endinterface

interface cbba_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [22:0] alloc_offset;
   logic [23:0] used_bytes;
   logic [23:0] free_bytes;
   modport source (output valid, status, alloc_offset, used_bytes, free_bytes, input ready);
   modport sink (input valid, status, alloc_offset, used_bytes, free_bytes, output ready);
endinterface

interface cbba_csr_if;
   logic        valid;
   logic        ready;
   logic [13:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

[sv/cbba_ram.sv]
// generic single write, single read ram with registered read data
`default_nettype none
module cbba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

[sv/colored_bitmap_block_allocator.sv]
// top level: colored bitmap block allocator with the color map in ram
//
// channel   | dir | payload                                          | word accepted
// req_chan  | in  | cmd, request_bytes, free_offset                  | valid & ready
// rsp_chan  | out | status, alloc_offset, used_bytes, free_bytes     | valid & ready
// csr_chan  | in  | block count of the region                        | valid & ready
//
// allocate: a load step, then the scan block by block, then the paint of each block of the run
// free: a look at the block, a walk back to the start of its run unless the block is block 0,
// then a clear and a check step per block; the map ram gives one read and one write per cycle
// a request failing the size, room or offset check goes straight to the response
// after reset and after each csr write a clearing pass writes zero to every map entry
// a finished word waits in the output register; the next request is taken meanwhile
`default_nettype none
module colored_bitmap_block_allocator (
   input wire logic  clock,
   input wire logic  reset,
   cbba_req_if.sink  req_chan,
   cbba_rsp_if.source rsp_chan,
   cbba_csr_if.sink  csr_chan
);
   import cbba_pkg::*;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      scan_ff, scan_in;
   logic [CNT_W-1:0]      run_len_ff, run_len_in;
   logic [CNT_W-1:0]      run_start_ff, run_start_in;
   logic [CNT_W-1:0]      need_ff, need_in;
   logic [CNT_W-1:0]      used_ff, used_in;
   logic [CNT_W-1:0]      total_ff, total_in;
   logic [CNT_W-1:0]      freed_ff, freed_in;
   logic [COLOR_W-1:0]    cur_ff, cur_in;
   logic [COLOR_W-1:0]    color_ff, color_in;
   logic [COLOR_W-1:0]    next_color_ff, next_color_in;
   logic                  prev_busy_ff, prev_busy_in;
   logic                  left_ok_ff, left_ok_in;
   status_type            status_ff, status_in;
   logic [OFFSET_W-1:0]   offset_ff, offset_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;
   logic [OFFSET_W-1:0]   rsp_offset_ff, rsp_offset_in;
   logic [BYTES_W-1:0]    rsp_used_ff, rsp_used_in;
   logic [BYTES_W-1:0]    rsp_free_ff, rsp_free_in;

   logic                  ram_we;
   logic [ADDR_W-1:0]     ram_waddr;
   logic [COLOR_W-1:0]    ram_wdata;
   logic [CNT_W-1:0]      ram_raddr;
   logic [COLOR_W-1:0]    ram_rdata;

   logic                  req_fire, csr_fire, out_free;
   logic [REQ_W:0]        round_sum;
   logic [NEED_W-1:0]     need_full;
   logic [CNT_W+BLK_SHIFT-1:0] region;
   logic [CNT_W-1:0]      unused;
   logic                  bad_size, no_room, bad_off;
   logic                  free_k, hit, right_ok, left_now, accept, scan_last;
   logic [CNT_W-1:0]      len_next, start_now, scan_inc, scan_dec;
   logic                  paint_last, chk_go;
   logic [COLOR_W-1:0]    color_step;

   cbba_ram #(.WIDTH(COLOR_W), .DEPTH(MAP_DEPTH)) u_map (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr[ADDR_W-1:0]),
      .rd_data (ram_rdata)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;
   assign req_fire = req_chan.valid && req_chan.ready;
   assign csr_fire = csr_chan.valid && csr_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.alloc_offset = rsp_offset_ff;
   assign rsp_chan.used_bytes   = rsp_used_ff;
   assign rsp_chan.free_bytes   = rsp_free_ff;

   // request checks
   assign round_sum = {1'b0, req_chan.request_bytes} + (REQ_W+1)'(BLOCK_BYTES - 1);
   assign need_full = round_sum[REQ_W:BLK_SHIFT];
   assign region    = {total_ff, BLK_SHIFT'(0)};
   assign unused    = (total_ff > used_ff) ? total_ff - used_ff : '0;
   assign bad_size  = (req_chan.request_bytes == '0)
                      || (32'(req_chan.request_bytes) > 32'(region));
   assign no_room   = need_full > NEED_W'(unused);
   assign bad_off   = 32'(req_chan.free_offset) >= 32'(region);

   // scan of element scan_ff with the following element on the ram output
   assign scan_inc  = scan_ff + CNT_W'(1);
   assign scan_dec  = scan_ff - CNT_W'(1);
   assign free_k    = (cur_ff == '0);
   assign len_next  = run_len_ff + CNT_W'(1);
   assign hit       = free_k && (len_next == need_ff);
   assign right_ok  = (scan_inc >= total_ff) || (ram_rdata == '0);
   assign left_now  = (run_len_ff == '0) ? !prev_busy_ff : left_ok_ff;
   assign start_now = (run_len_ff == '0) ? scan_ff : run_start_ff;
   assign accept    = hit && left_now && right_ok;
   assign scan_last = (scan_inc == total_ff);

   assign paint_last = (scan_inc == run_start_ff + need_ff);
   assign chk_go     = (scan_ff < total_ff) && (ram_rdata == color_ff);
   assign color_step = (next_color_ff + COLOR_W'(1) == '0) ? COLOR_W'(1)
                       : next_color_ff + COLOR_W'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (scan_ff == CNT_W'(MAP_DEPTH - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (req_chan.cmd == CMD_ALLOC) begin
                  state_in = (bad_size || no_room) ? ST_RESP : ST_ALLOC_LOAD;
               end else begin
                  state_in = bad_off ? ST_RESP : ST_FREE_LOOK;
               end
            end
         end
         ST_ALLOC_LOAD: state_in = ST_ALLOC_SCAN;
         ST_ALLOC_SCAN: begin
            if (accept) state_in = ST_ALLOC_PAINT;
            else if (scan_last) state_in = ST_RESP;
         end
         ST_ALLOC_PAINT: begin
            if (paint_last) state_in = ST_RESP;
         end
         ST_FREE_LOOK: begin
            if (ram_rdata == '0) state_in = ST_RESP;
            else if (scan_ff == '0) state_in = ST_FREE_CLR;
            else state_in = ST_FREE_BACK;
         end
         ST_FREE_BACK: begin
            if (ram_rdata != color_ff || scan_dec == '0) state_in = ST_FREE_CLR;
         end
         ST_FREE_CLR: state_in = ST_FREE_CHK;
         ST_FREE_CHK: state_in = chk_go ? ST_FREE_CLR : ST_RESP;
         ST_RESP: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
      if (csr_fire) state_in = ST_CLEAR;
   end

   // datapath and ram control
   always_comb begin
      scan_in       = scan_ff;
      run_len_in    = run_len_ff;
      run_start_in  = run_start_ff;
      need_in       = need_ff;
      used_in       = used_ff;
      total_in      = total_ff;
      freed_in      = freed_ff;
      cur_in        = cur_ff;
      color_in      = color_ff;
      next_color_in = next_color_ff;
      prev_busy_in  = prev_busy_ff;
      left_ok_in    = left_ok_ff;
      status_in     = status_ff;
      offset_in     = offset_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_used_in   = rsp_used_ff;
      rsp_free_in   = rsp_free_ff;
      ram_we        = 1'b0;
      ram_waddr     = scan_ff[ADDR_W-1:0];
      ram_wdata     = '0;
      ram_raddr     = scan_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_we  = 1'b1;
            scan_in = scan_inc;
         end
         ST_IDLE: begin
            if (req_fire) begin
               offset_in  = '0;
               freed_in   = '0;
               need_in    = CNT_W'(need_full);
               scan_in    = '0;
               run_len_in = '0;
               if (req_chan.cmd == CMD_ALLOC) begin
                  ram_raddr = '0;
                  if (bad_size) status_in = STAT_BAD_SIZE;
                  else if (no_room) status_in = STAT_NO_SPACE;
               end else begin
                  scan_in   = CNT_W'(req_chan.free_offset >> BLK_SHIFT);
                  ram_raddr = CNT_W'(req_chan.free_offset >> BLK_SHIFT);
                  if (bad_off) status_in = STAT_BAD_OFFSET;
               end
            end
         end
         ST_ALLOC_LOAD: begin
            cur_in       = ram_rdata;
            ram_raddr    = CNT_W'(1);
            prev_busy_in = 1'b0;
         end
         ST_ALLOC_SCAN: begin
            ram_raddr = scan_ff + CNT_W'(2);
            if (accept) begin
               run_start_in  = start_now;
               scan_in       = start_now;
               color_in      = next_color_ff;
               next_color_in = color_step;
            end else begin
               run_len_in   = (!free_k || hit) ? '0 : len_next;
               left_ok_in   = left_now;
               run_start_in = start_now;
               prev_busy_in = !free_k;
               cur_in       = ram_rdata;
               scan_in      = scan_inc;
               if (scan_last) status_in = STAT_NO_SPACE;
            end
         end
         ST_ALLOC_PAINT: begin
            ram_we    = 1'b1;
            ram_wdata = color_ff;
            scan_in   = scan_inc;
            if (paint_last) begin
               used_in   = used_ff + need_ff;
               status_in = STAT_OK;
               offset_in = OFFSET_W'({run_start_ff, BLK_SHIFT'(0)});
            end
         end
         ST_FREE_LOOK: begin
            color_in  = ram_rdata;
            ram_raddr = scan_dec;
            if (ram_rdata == '0) status_in = STAT_BAD_OFFSET;
         end
         ST_FREE_BACK: begin
            ram_raddr = scan_ff - CNT_W'(2);
            if (ram_rdata == color_ff) scan_in = scan_dec;
         end
         ST_FREE_CLR: begin
            ram_we    = 1'b1;
            ram_raddr = scan_inc;
            scan_in   = scan_inc;
            freed_in  = freed_ff + CNT_W'(1);
         end
         ST_FREE_CHK: begin
            if (!chk_go) begin
               used_in   = (used_ff >= freed_ff) ? used_ff - freed_ff : '0;
               status_in = STAT_OK;
            end
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_offset_in = offset_ff;
               rsp_used_in   = BYTES_W'({used_ff, BLK_SHIFT'(0)});
               rsp_free_in   = BYTES_W'({unused, BLK_SHIFT'(0)});
            end
         end
         default: ;
      endcase
      if (csr_fire) begin
         total_in      = (32'(csr_chan.data) > 32'(MAP_DEPTH)) ? CNT_W'(MAP_DEPTH)
                         : CNT_W'(csr_chan.data);
         used_in       = '0;
         next_color_in = COLOR_W'(1);
         scan_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         scan_ff       <= '0;
         used_ff       <= '0;
         total_ff      <= CNT_W'(RESET_TOTAL);
         next_color_ff <= COLOR_W'(1);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scan_ff       <= scan_in;
         used_ff       <= used_in;
         total_ff      <= total_in;
         next_color_ff <= next_color_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      run_len_ff    <= run_len_in;
      run_start_ff  <= run_start_in;
      need_ff       <= need_in;
      freed_ff      <= freed_in;
      cur_ff        <= cur_in;
      color_ff      <= color_in;
      prev_busy_ff  <= prev_busy_in;
      left_ok_ff    <= left_ok_in;
      status_ff     <= status_in;
      offset_ff     <= offset_in;
      rsp_status_ff <= rsp_status_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_used_ff   <= rsp_used_in;
      rsp_free_ff   <= rsp_free_in;
   end
endmodule
`default_nettype wire

[sv/cbba_checker.sv]
// port level checks of the allocator and their bind to the top level
`default_nettype none
module cbba_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_status,
   input wire logic [22:0] rsp_alloc_offset,
   input wire logic [23:0] rsp_used_bytes,
   input wire logic [23:0] rsp_free_bytes
);
   import cbba_pkg::*;

   // a word that waits stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // used and free together never exceed the map
   a_bytes_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_used_bytes) + 32'(rsp_free_bytes)
                     <= 32'(MAP_DEPTH) * 32'(BLOCK_BYTES)))
      else $error("used plus free bytes exceed region");

   // failures carry no offset
   a_fail_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STAT_OK) |-> (rsp_alloc_offset == '0))
      else $error("offset on failed operation");

   // byte counts and offsets are whole blocks
   a_block_align: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_used_bytes[BLK_SHIFT-1:0] == '0)
                    && (rsp_free_bytes[BLK_SHIFT-1:0] == '0)
                    && (rsp_alloc_offset[BLK_SHIFT-1:0] == '0))
      else $error("byte count not block aligned");
endmodule

bind colored_bitmap_block_allocator cbba_checker u_cbba_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_status       (rsp_chan.status),
   .rsp_alloc_offset (rsp_chan.alloc_offset),
   .rsp_used_bytes   (rsp_chan.used_bytes),
   .rsp_free_bytes   (rsp_chan.free_bytes)
);
`default_nettype wire

[verif/testbench.sv]
// testbench for the colored bitmap block allocator: directed table, then random traffic
`timescale 1ns / 100ps
`default_nettype none
module testbench;
   import cbba_pkg::*;

   localparam int IDLE_LIMIT = 80000;
   localparam int FULL_BYTES = MAP_DEPTH * BLOCK_BYTES;

   typedef struct packed {
      status_type  status;
      logic [22:0] alloc_offset;
      logic [23:0] used_bytes;
      logic [23:0] free_bytes;
   } outcome_type;

   typedef struct {
      cmd_type cmd;
      int      bytes;
      int      offs;
      bit      typed;
      outcome_type want;
   } row_type;

   logic clock;
   logic reset;
   cbba_req_if req ();
   cbba_rsp_if rsp ();
   cbba_csr_if csr ();

   colored_bitmap_block_allocator dut (
      .clock(clock), .reset(reset), .req_chan(req), .rsp_chan(rsp), .csr_chan(csr)
   );

   // local copy of the allocator state
   byte unsigned color_map [MAP_DEPTH];
   int next_color;
   int busy_blks;
   int region_blks;

   outcome_type pending_q [$];
   int errors = 0;
   int idle_cycles = 0;
   int sent = 0;
   int n_alloc_ok = 0, n_alloc_fail = 0, n_free_ok = 0, n_free_bad = 0;
   bit quiet = 0;
   bit held = 0;

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   function automatic void clear_state(int total);
      foreach (color_map[i]) color_map[i] = 0;
      next_color = 1;
      busy_blks = 0;
      region_blks = (total > MAP_DEPTH) ? MAP_DEPTH : total;
   endfunction

   function automatic outcome_type predict_word(cmd_type cmd, int bytes, int offs);
      outcome_type o;
      int region, need, unused, run_start, run_len, blk, c, fin;
      region = region_blks * BLOCK_BYTES;
      o.status = STAT_OK;
      o.alloc_offset = 0;
      if (cmd == CMD_ALLOC) begin
         unused = (region_blks > busy_blks) ? region_blks - busy_blks : 0;
         need = (bytes + BLOCK_BYTES - 1) / BLOCK_BYTES;
         if (bytes == 0 || bytes > region) o.status = STAT_BAD_SIZE;
         else if (need > unused) o.status = STAT_NO_SPACE;
         else begin
            o.status = STAT_NO_SPACE;
            run_start = 0;
            run_len = 0;
            for (int i = 0; i < region_blks; i++) begin
               if (color_map[i] != 0) begin
                  run_len = 0;
                  continue;
               end
               if (run_len == 0) run_start = i;
               run_len++;
               if (run_len == need) begin
                  fin = run_start + need;
                  // a neighbor in use rejects the run and restarts the count
                  if (run_start > 0 && color_map[run_start-1] != 0) begin
                     run_len = 0;
                     continue;
                  end
                  if (fin < region_blks && color_map[fin] != 0) begin
                     run_len = 0;
                     continue;
                  end
                  for (int j = run_start; j < fin; j++) color_map[j] = next_color[7:0];
                  next_color = (next_color + 1) & 8'hFF;
                  if (next_color == 0) next_color = 1;
                  busy_blks += need;
                  o.status = STAT_OK;
                  o.alloc_offset = 23'(run_start * BLOCK_BYTES);
                  break;
               end
            end
         end
      end else begin
         if (offs >= region) o.status = STAT_BAD_OFFSET;
         else begin
            blk = offs / BLOCK_BYTES;
            c = color_map[blk];
            if (c == 0) o.status = STAT_BAD_OFFSET;
            else begin
               fin = 0;
               while (blk > 0 && color_map[blk-1] == c) blk--;
               while (blk < region_blks && color_map[blk] == c) begin
                  color_map[blk] = 0;
                  blk++;
                  fin++;
               end
               busy_blks = (busy_blks >= fin) ? busy_blks - fin : 0;
            end
         end
      end
      unused = (region_blks > busy_blks) ? region_blks - busy_blks : 0;
      o.used_bytes = 24'(busy_blks * BLOCK_BYTES);
      o.free_bytes = 24'(unused * BLOCK_BYTES);
      return o;
   endfunction

   task automatic drain_results();
      while (pending_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_total(int value);
      drain_results();
      repeat (40) @(posedge clock);
      csr.valid <= 1;
      csr.data <= 14'(value);
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      csr.valid <= 0;
      clear_state(value & 16'h3FFF);
   endtask

   task automatic send_word(cmd_type cmd, int bytes, int offs, bit typed,
                            outcome_type want);
      outcome_type got;
      req.valid <= 1;
      req.cmd <= cmd;
      req.request_bytes <= 24'(bytes);
      req.free_offset <= 24'(offs);
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      got = predict_word(cmd, bytes, offs);
      if (typed && got != want) begin
         $error("predictor disagrees with table row %0d", sent);
         errors++;
      end
      pending_q.push_back(got);
      sent++;
      if (cmd == CMD_ALLOC) begin
         if (got.status == STAT_OK) n_alloc_ok++; else n_alloc_fail++;
      end else begin
         if (got.status == STAT_OK) n_free_ok++; else n_free_bad++;
      end
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req.valid <= 0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic random_word();
      int r, k, cap, blk, bytes, offs;
      outcome_type none;
      cmd_type cmd;
      none = '{STAT_OK, 0, 0, 0};
      r = $urandom_range(0, 99);
      bytes = $urandom & 24'hFFFFFF;
      offs = $urandom & 24'hFFFFFF;
      cmd = cmd_type'($urandom_range(0, 1));
      if (region_blks > 0 && r < 50) begin
         cmd = CMD_ALLOC;
         cap = (region_blks <= 300) ? region_blks / 4 + 1 : 16;
         k = $urandom_range(1, cap);
         if ($urandom_range(0, 19) == 0) k = $urandom_range(1, region_blks);
         bytes = (k - 1) * BLOCK_BYTES + $urandom_range(1, BLOCK_BYTES);
      end else if (region_blks > 0 && r < 85) begin
         cmd = CMD_FREE;
         // look for a block in use so most frees hit a live run
         blk = $urandom_range(0, region_blks - 1);
         for (int t = 0; t < 8 && color_map[blk] == 0; t++)
            blk = $urandom_range(0, region_blks - 1);
         offs = blk * BLOCK_BYTES + $urandom_range(0, BLOCK_BYTES - 1);
      end else if (r < 92) begin
         // region edges
         bytes = region_blks * BLOCK_BYTES + $urandom_range(0, 1);
         offs = region_blks * BLOCK_BYTES - $urandom_range(0, 1);
         if (offs < 0) offs = 0;
      end
      send_word(cmd, bytes, offs, 0, none);
   endtask

   // response side: check each word against the oldest prediction
   always @(posedge clock) begin
      outcome_type w;
      if (reset) idle_cycles <= 0;
      else if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (csr.valid && csr.ready))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_q.size() == 0) begin
            $error("response word with nothing expected");
            errors++;
         end else begin
            w = pending_q.pop_front();
            if (rsp.status !== w.status) begin
               $error("status: expected %0d, got %0d", w.status, rsp.status);
               errors++;
            end
            if (rsp.alloc_offset !== w.alloc_offset) begin
               $error("alloc_offset: expected %0d, got %0d", w.alloc_offset, rsp.alloc_offset);
               errors++;
            end
            if (rsp.used_bytes !== w.used_bytes) begin
               $error("used_bytes: expected %0d, got %0d", w.used_bytes, rsp.used_bytes);
               errors++;
            end
            if (rsp.free_bytes !== w.free_bytes) begin
               $error("free_bytes: expected %0d, got %0d", w.free_bytes, rsp.free_bytes);
               errors++;
            end
         end
      end
   end

   // receiver: random stall bursts, one long hold-off so the block backs up
   initial begin
      rsp.ready <= 0;
      forever begin
         @(posedge clock);
         if (quiet) rsp.ready <= 1;
         else if (!held && sent >= 420) begin
            held = 1;
            rsp.ready <= 0;
            repeat (400) @(posedge clock);
            rsp.ready <= 1;
         end else if ($urandom_range(0, 3) == 0) begin
            rsp.ready <= 0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            rsp.ready <= 1;
         end else begin
            rsp.ready <= 1;
            repeat ($urandom_range(0, 15)) @(posedge clock);
         end
      end
   end

   initial begin
      @(posedge clock);
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("timeout after %0d idle cycles", IDLE_LIMIT);
      $display("testbench NOT OK");
      $finish;
   end

   initial begin
      row_type rows [12];
      int totals [8];
      int counts [8];
      rows[0]  = '{CMD_ALLOC, 0, 0, 1, '{STAT_BAD_SIZE, 0, 0, FULL_BYTES}};
      rows[1]  = '{CMD_ALLOC, 24'hFFFFFF, 0, 1, '{STAT_BAD_SIZE, 0, 0, FULL_BYTES}};
      rows[2]  = '{CMD_ALLOC, 1, 0, 1, '{STAT_OK, 0, 1024, FULL_BYTES - 1024}};
      // block 1 is rejected since block 0 next to it is in use
      rows[3]  = '{CMD_ALLOC, 1024, 0, 1, '{STAT_OK, 2048, 2048, FULL_BYTES - 2048}};
      rows[4]  = '{CMD_ALLOC, FULL_BYTES, 0, 1, '{STAT_NO_SPACE, 0, 2048, FULL_BYTES - 2048}};
      rows[5]  = '{CMD_FREE, 0, 24'hFFFFFF, 1, '{STAT_BAD_OFFSET, 0, 2048, FULL_BYTES - 2048}};
      rows[6]  = '{CMD_FREE, 0, 1024, 1, '{STAT_BAD_OFFSET, 0, 2048, FULL_BYTES - 2048}};
      rows[7]  = '{CMD_FREE, 24'hFFFFFF, 2500, 1, '{STAT_OK, 0, 1024, FULL_BYTES - 1024}};
      rows[8]  = '{CMD_FREE, 0, 0, 1, '{STAT_OK, 0, 0, FULL_BYTES}};
      rows[9]  = '{CMD_ALLOC, FULL_BYTES, 0, 1, '{STAT_OK, 0, FULL_BYTES, 0}};
      rows[10] = '{CMD_ALLOC, 1, 0, 1, '{STAT_NO_SPACE, 0, FULL_BYTES, 0}};
      rows[11] = '{CMD_FREE, 0, FULL_BYTES - 1, 1, '{STAT_OK, 0, 0, FULL_BYTES}};
      totals = '{1, 16, 0, 64, 300, 8192, 16383, 37};
      counts = '{80, 200, 30, 300, 300, 60, 40, 160};

      reset <= 1;
      req.valid <= 0;
      req.cmd <= CMD_ALLOC;
      req.request_bytes <= 0;
      req.free_offset <= 0;
      csr.valid <= 0;
      csr.data <= 0;
      clear_state(RESET_TOTAL);
      repeat (6) @(posedge clock);
      reset <= 0;

      foreach (rows[i]) send_word(rows[i].cmd, rows[i].bytes, rows[i].offs, rows[i].typed,
                                  rows[i].want);
      for (int i = 0; i < 6; i++) random_word();

      for (int p = 0; p < 8; p++) begin
         if (p == 7) quiet = 1;
         req.valid <= 0;
         write_total(totals[p]);
         for (int n = 0; n < counts[p]; n++) begin
            // sender waits here until every result has come back
            if (p == 4 && n == 150) begin
               req.valid <= 0;
               @(posedge clock);
               drain_results();
            end
            random_word();
         end
      end
      req.valid <= 0;
      drain_results();
      repeat (200) @(posedge clock);

      $display("%0d words sent over 9 region settings from 0 blocks to the full map", sent);
      $display("allocs ok %0d failed %0d, frees ok %0d rejected %0d",
               n_alloc_ok, n_alloc_fail, n_free_ok, n_free_bad);
      if (errors == 0 && pending_q.size() == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end
endmodule
`default_nettype wire

[sim.f]
sv/cbba_pkg.sv
sv/cbba_if.sv
sv/cbba_ram.sv
sv/colored_bitmap_block_allocator.sv
sv/cbba_checker.sv
verif/testbench.sv
